[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, quiet while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/bsmv_pkg.sv]
// ----------------------------------------------------------------------------
// bsmv_pkg
// Types and constants of the binary sparse mat-vec power unit.
// ----------------------------------------------------------------------------
package bsmv_pkg;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_LOAD  = 2'd2,
      REQ_START = 2'd3
   } req_kind_type;

   localparam logic [1:0] CSR_DIMENSION   = 2'd0;
   localparam logic [1:0] CSR_CHAIN_MODE  = 2'd1;
   localparam logic [1:0] CSR_POWER_COUNT = 2'd2;

   localparam logic [6:0] DIM_RESET = 7'd64;

   typedef struct packed {
      req_kind_type kind;
      logic [5:0]   row;
      logic [5:0]   col;
      logic [5:0]   vix;
      logic [31:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [6:0] dimension;
      logic       chain_mode;
      logic [3:0] power_count;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P_INIT,
      ST_P_RDNZ,
      ST_P_RDOP,
      ST_P_ACC,
      ST_SAT_RD,
      ST_SAT_WR,
      ST_OUT_RD,
      ST_OUT_WR
   } back_state_type;

endpackage

[design/bsmv_ram.sv]
// ----------------------------------------------------------------------------
// bsmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[design/bsmv_front.sv]
// ----------------------------------------------------------------------------
// bsmv_front
// Request intake: decodes each beat and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module bsmv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_type,
   input  logic [5:0]        req_row_index,
   input  logic [5:0]        req_col_index,
   input  logic [5:0]        req_vector_index,
   input  logic [31:0]       req_vector_value,
   output logic              cmd_valid,
   output bsmv_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import bsmv_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   cmd_type    beat;

   always_comb begin
      beat.kind  = req_kind_type'(req_type);
      beat.row   = req_row_index;
      beat.col   = req_col_index;
      beat.vix   = req_vector_index;
      beat.value = req_vector_value;
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= beat;
      end
   end
endmodule

[design/bsmv_back.sv]
// ----------------------------------------------------------------------------
// bsmv_back
// Execution engine: vector/nonzero stores, pass sequencer, result register.
// ----------------------------------------------------------------------------
module bsmv_back #(
   parameter int MAX_DIM      = 64,
   parameter int MAX_NONZEROS = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  bsmv_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  bsmv_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output logic [5:0]        rsp_result_index,
   output logic [47:0]       rsp_result_value,
   output logic              rsp_last_flag,
   output logic              rsp_error_flag
);
   import bsmv_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int NZ_AW  = $clog2(MAX_NONZEROS);
   localparam int CNT_W  = $clog2(MAX_NONZEROS + 1);
   localparam int SW     = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
   localparam logic signed [64:0] ACC_HI = 65'sd1 <<< 62;
   localparam logic signed [64:0] ACC_LO = -(65'sd1 <<< 62);
   localparam logic signed [63:0] OUT_HI = (64'sd1 <<< 47) - 64'sd1;
   localparam logic signed [63:0] OUT_LO = -(64'sd1 <<< 47);

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] nz_cnt_ff, nz_cnt_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [4:0]       p_ff, p_in;
   logic             err_ff, err_in;
   logic [DIM_W-1:0] d_ff, d_in;
   logic             src_vld_ff, src_vld_in, dst_vld_ff, dst_vld_in;
   logic [MAX_DIM-1:0] ivec_vld_ff, ivec_vld_in;
   logic [MAX_DIM-1:0] bank_vld_ff [2];
   logic [MAX_DIM-1:0] bank_vld_in [2];

   logic             out_vld_ff, out_vld_in;
   logic [5:0]       out_idx_ff, out_idx_in;
   logic [47:0]      out_val_ff, out_val_in;
   logic             out_last_ff, out_last_in;
   logic             out_err_ff, out_err_in;

   // memory ports
   logic             nz_we;
   logic [NZ_AW-1:0] nz_waddr, nz_raddr;
   logic [11:0]      nz_wdata, nz_rdata;
   logic             iv_we;
   logic [DIM_W-1:0] iv_waddr, iv_raddr;
   logic [SW-1:0]    iv_wdata, iv_rdata;
   logic             bk_we [2];
   logic [DIM_W-1:0] bk_waddr;
   logic [DIM_W-1:0] bk_raddr [2];
   logic [63:0]      bk_wdata;
   logic [63:0]      bk_rdata [2];

   logic [6:0]       n_use, n_last;
   logic             db, tr, last_pass, j_end, k_end, out_free;
   logic [5:0]       nz_r, nz_c, nz_d, nz_s;
   logic             nz_bad;
   logic signed [63:0] src_val, dst_val, sat_in;
   logic signed [64:0] sum;
   logic signed [63:0] acc_val, sat_val;
   logic             sat_hit;

   // ---- stores ----
   bsmv_ram #(.WIDTH(12), .DEPTH(MAX_NONZEROS)) u_nz_ram (
      .clock(clock), .we(nz_we), .waddr(nz_waddr), .wdata(nz_wdata),
      .raddr(nz_raddr), .rdata(nz_rdata));

   bsmv_ram #(.WIDTH(SW), .DEPTH(MAX_DIM)) u_iv_ram (
      .clock(clock), .we(iv_we), .waddr(iv_waddr), .wdata(iv_wdata),
      .raddr(iv_raddr), .rdata(iv_rdata));

   for (genvar b = 0; b < 2; b++) begin : g_bank
      bsmv_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_bank_ram (
         .clock(clock), .we(bk_we[b]), .waddr(bk_waddr), .wdata(bk_wdata),
         .raddr(bk_raddr[b]), .rdata(bk_rdata[b]));
   end

   // ---- datapath ----
   always_comb begin
      if (cfg.dimension == 7'd0) begin
         n_use = 7'd1;
      end else if (cfg.dimension > 7'(MAX_DIM)) begin
         n_use = 7'(MAX_DIM);
      end else begin
         n_use = cfg.dimension;
      end
   end

   assign n_last    = n_use - 7'd1;
   assign db        = p_ff[0];
   assign tr        = cfg.chain_mode ^ p_ff[0];
   assign last_pass = (p_ff == {cfg.power_count, 1'b0});
   assign j_end     = (7'(j_ff) == n_last);
   assign k_end     = ((k_ff + CNT_W'(1)) == nz_cnt_ff);
   assign out_free  = !out_vld_ff || pop;

   assign nz_r   = nz_rdata[11:6];
   assign nz_c   = nz_rdata[5:0];
   assign nz_bad = (7'(nz_r) >= n_use) || (7'(nz_c) >= n_use);
   assign nz_d   = tr ? nz_c : nz_r;
   assign nz_s   = tr ? nz_r : nz_c;

   assign nz_we    = (state_ff == ST_IDLE) && cmd_valid && (cmd.kind == REQ_ADD) &&
                     (7'(cmd.row) < n_use) && (7'(cmd.col) < n_use) &&
                     (nz_cnt_ff < CNT_W'(MAX_NONZEROS));
   assign nz_waddr = nz_cnt_ff[NZ_AW-1:0];
   assign nz_wdata = {cmd.row, cmd.col};
   assign nz_raddr = k_ff[NZ_AW-1:0];

   assign iv_we    = (state_ff == ST_IDLE) && cmd_valid && (cmd.kind == REQ_LOAD) &&
                     (7'(cmd.vix) < n_use);
   assign iv_waddr = cmd.vix[DIM_W-1:0];
   assign iv_wdata = cmd.value[SW-1:0];
   assign iv_raddr = nz_s[DIM_W-1:0];

   // destination bank follows the accumulate address during the walk,
   // the sweep counter otherwise; the other bank is the pass source
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         if (db == b[0]) begin
            bk_raddr[b] = (state_ff == ST_P_RDOP) ? nz_d[DIM_W-1:0] : j_ff;
         end else begin
            bk_raddr[b] = nz_s[DIM_W-1:0];
         end
         bk_we[b] = ((state_ff == ST_P_ACC) || (state_ff == ST_SAT_WR)) && (db == b[0]);
      end
   end

   assign bk_waddr = (state_ff == ST_P_ACC) ? d_ff : j_ff;

   always_comb begin
      if (!src_vld_ff) begin
         src_val = 64'sd0;
      end else if (p_ff == 5'd0) begin
         src_val = 64'($signed(iv_rdata));
      end else begin
         src_val = $signed(bk_rdata[~db]);
      end
      dst_val = dst_vld_ff ? $signed(bk_rdata[db]) : 64'sd0;
      sum = 65'(dst_val) + 65'(src_val);
      if (sum > ACC_HI) begin
         acc_val = 64'(ACC_HI);
      end else if (sum < ACC_LO) begin
         acc_val = 64'(ACC_LO);
      end else begin
         acc_val = 64'(sum);
      end
      sat_in  = bank_vld_ff[db][j_ff] ? $signed(bk_rdata[db]) : 64'sd0;
      sat_hit = (sat_in > OUT_HI) || (sat_in < OUT_LO);
      if (sat_in > OUT_HI) begin
         sat_val = OUT_HI;
      end else if (sat_in < OUT_LO) begin
         sat_val = OUT_LO;
      end else begin
         sat_val = sat_in;
      end
   end

   assign bk_wdata = (state_ff == ST_P_ACC) ? acc_val : sat_val;

   // ---- sequencer ----
   always_comb begin
      state_in    = state_ff;
      nz_cnt_in   = nz_cnt_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      p_in        = p_ff;
      err_in      = err_ff;
      d_in        = d_ff;
      src_vld_in  = src_vld_ff;
      dst_vld_in  = dst_vld_ff;
      ivec_vld_in = ivec_vld_ff;
      bank_vld_in = bank_vld_ff;
      out_vld_in  = out_vld_ff && !pop;
      out_idx_in  = out_idx_ff;
      out_val_in  = out_val_ff;
      out_last_in = out_last_ff;
      out_err_in  = out_err_ff;
      cmd_pop     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               unique case (cmd.kind)
                  REQ_CLEAR: begin
                     ivec_vld_in = '0;
                     nz_cnt_in   = '0;
                     err_in      = 1'b0;
                  end
                  REQ_ADD: begin
                     if (nz_we) begin
                        nz_cnt_in = nz_cnt_ff + CNT_W'(1);
                     end else begin
                        err_in = 1'b1;
                     end
                  end
                  REQ_LOAD: begin
                     if (iv_we) begin
                        ivec_vld_in[iv_waddr] = 1'b1;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
                  REQ_START: begin
                     p_in     = 5'd0;
                     state_in = ST_P_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_P_INIT: begin
            bank_vld_in[db] = '0;
            k_in = '0;
            j_in = '0;
            state_in = (nz_cnt_ff == '0) ? ST_SAT_RD : ST_P_RDNZ;
         end
         ST_P_RDNZ: begin
            state_in = ST_P_RDOP;
         end
         ST_P_RDOP: begin
            if (nz_bad) begin
               // stale entry left over from a larger dimension
               err_in = 1'b1;
               k_in   = k_ff + CNT_W'(1);
               state_in = k_end ? ST_SAT_RD : ST_P_RDNZ;
            end else begin
               d_in = nz_d[DIM_W-1:0];
               src_vld_in = (p_ff == 5'd0) ? ivec_vld_ff[nz_s[DIM_W-1:0]]
                                           : bank_vld_ff[~db][nz_s[DIM_W-1:0]];
               dst_vld_in = bank_vld_ff[db][nz_d[DIM_W-1:0]];
               state_in = ST_P_ACC;
            end
         end
         ST_P_ACC: begin
            bank_vld_in[db][d_ff] = 1'b1;
            k_in = k_ff + CNT_W'(1);
            state_in = k_end ? ST_SAT_RD : ST_P_RDNZ;
         end
         ST_SAT_RD: begin
            state_in = ST_SAT_WR;
         end
         ST_SAT_WR: begin
            bank_vld_in[db][j_ff] = 1'b1;
            if (sat_hit) begin
               err_in = 1'b1;
            end
            if (!j_end) begin
               j_in = j_ff + DIM_W'(1);
               state_in = ST_SAT_RD;
            end else if (last_pass) begin
               j_in = '0;
               state_in = ST_OUT_RD;
            end else begin
               p_in = p_ff + 5'd1;
               state_in = ST_P_INIT;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_WR;
         end
         ST_OUT_WR: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_idx_in  = 6'(j_ff);
               out_val_in  = bank_vld_ff[db][j_ff] ? bk_rdata[db][47:0] : 48'd0;
               out_last_in = j_end;
               out_err_in  = err_ff;
               if (j_end) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + DIM_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         nz_cnt_ff   <= '0;
         err_ff      <= 1'b0;
         ivec_vld_ff <= '0;
         bank_vld_ff <= '{default: '0};
         out_vld_ff  <= 1'b0;
         k_ff        <= '0;
         j_ff        <= '0;
         p_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         nz_cnt_ff   <= nz_cnt_in;
         err_ff      <= err_in;
         ivec_vld_ff <= ivec_vld_in;
         bank_vld_ff <= bank_vld_in;
         out_vld_ff  <= out_vld_in;
         k_ff        <= k_in;
         j_ff        <= j_in;
         p_ff        <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      src_vld_ff  <= src_vld_in;
      dst_vld_ff  <= dst_vld_in;
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign empty            = !out_vld_ff;
   assign rsp_result_index = out_idx_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_last_flag    = out_last_ff;
   assign rsp_error_flag   = out_err_ff;
endmodule

[design/binary_sparse_matvec_power_unit.sv]
// ----------------------------------------------------------------------------
// binary_sparse_matvec_power_unit
// Power-iteration product of a 0/1 sparse matrix with a dense Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage:
//  - Request queue (push/full): clear, add nonzero (row,col), load vector
//    element, start. A beat enters when push is high and full is low. A
//    two-entry queue sits ahead of the engine, so beats keep landing while
//    the engine is busy or a result sits unread.
//  - Clear, add and load retire in the engine without leaving the idle state.
//  - Start runs 2q+1 passes. Each pass takes three steps per stored nonzero
//    (list read, operand read, accumulate write, set by the single read port
//    of each bank) plus a saturation read and write per element. Then n
//    result beats follow, each read and then written to the output register.
//  - Result queue (empty/pop): one output register; when pop stays low the
//    engine holds at the current element and the request side fills up.
//  - CSR channel (csr_valid/csr_ready, always ready): dimension, chain_mode,
//    power_count; user must write only while the unit is idle (unchecked).
//  - Reset: both queues empty, config back to defaults, vector and
//    nonzero count zeroed through valid bits (no clearing sweep).
// ----------------------------------------------------------------------------
module binary_sparse_matvec_power_unit #(
   parameter int MAX_DIM      = 64,
   parameter int MAX_NONZEROS = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_row_index,
   input  logic [5:0]  req_col_index,
   input  logic [5:0]  req_vector_index,
   input  logic [31:0] req_vector_value,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_result_index,
   output logic [47:0] rsp_result_value,
   output logic        rsp_last_flag,
   output logic        rsp_error_flag,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import bsmv_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid, cmd_pop;

   // config registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DIMENSION:   cfg_in.dimension   = csr_wdata;
            CSR_CHAIN_MODE:  cfg_in.chain_mode  = csr_wdata[0];
            CSR_POWER_COUNT: cfg_in.power_count = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dimension   <= DIM_RESET;
         cfg_ff.chain_mode  <= 1'b0;
         cfg_ff.power_count <= 4'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: intake and decode
   bsmv_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_type(req_type), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_vector_index(req_vector_index),
      .req_vector_value(req_vector_value),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

   // back: stores, pass sequencer, result register
   bsmv_back #(
      .MAX_DIM(MAX_DIM), .MAX_NONZEROS(MAX_NONZEROS), .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .empty(empty), .pop(pop),
      .rsp_result_index(rsp_result_index), .rsp_result_value(rsp_result_value),
      .rsp_last_flag(rsp_last_flag), .rsp_error_flag(rsp_error_flag));
endmodule

[design/bsmv_checker.sv]
// ----------------------------------------------------------------------------
// bsmv_checker
// Port-level checks on the power unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [5:0]  rsp_result_index,
   input logic [47:0] rsp_result_value,
   input logic        rsp_last_flag
);
   `CHK_NEXT(a_idx_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_result_index))
   `CHK_NEXT(a_val_hold, clock, reset, !empty && !pop, $stable(rsp_result_value))
   `CHK_NEXT(a_last_hold, clock, reset, !empty && !pop, $stable(rsp_last_flag))
   `CHK_NEXT_ALWAYS(a_reset_empty, clock, reset, empty && !full)
endmodule

bind binary_sparse_matvec_power_unit bsmv_checker u_bsmv_checker (.*);

[tb/sv/tb_binary_sparse_matvec_power_unit.sv]
// ----------------------------------------------------------------------------
// tb_binary_sparse_matvec_power_unit
// Self-checking bench: sparse 0/1 matrix power-iteration products.
// ----------------------------------------------------------------------------
// Directed phases, then random phases. Each phase programs the CSRs while
// the unit is idle, then streams clear/add/load/start beats. A behavioral
// model in this file predicts every result beat; the monitor compares each
// popped beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_binary_sparse_matvec_power_unit;
   import bsmv_pkg::*;

   localparam int DIM_MAX  = 64;
   localparam int NZ_MAX   = 1024;
   localparam int WDOG_LIM = 400000;

   typedef struct packed {
      logic [5:0]  idx;
      logic [47:0] value;
      logic        last;
      logic        err;
   } elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_type = REQ_CLEAR;
   logic [5:0]  req_row_index = '0;
   logic [5:0]  req_col_index = '0;
   logic [5:0]  req_vector_index = '0;
   logic [31:0] req_vector_value = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [5:0]  rsp_result_index;
   logic [47:0] rsp_result_value;
   logic        rsp_last_flag;
   logic        rsp_error_flag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   binary_sparse_matvec_power_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   logic [6:0]        m_dim;
   logic              m_mode;
   logic [3:0]        m_rounds;
   logic signed [63:0] m_vec [DIM_MAX];
   logic [11:0]       m_nz [NZ_MAX];
   int                m_nnz;
   logic              m_err;

   cmd_type  cmd_q [$];
   elem_type want_q [$];
   int       n_beats_in, n_beats_out, n_starts;
   int       errors;
   bit       quiet;      // no idling at the end of the run
   int       cycles_idle;

   // one pass: transposed adds src[row] into dst[col]
   function automatic void sparse_pass(input logic signed [63:0] src [DIM_MAX],
                                       output logic signed [63:0] dst [DIM_MAX],
                                       input int n, input bit tr);
      logic signed [63:0] a;
      int r, c;
      for (int i = 0; i < DIM_MAX; i++) dst[i] = 0;
      for (int k = 0; k < m_nnz; k++) begin
         r = m_nz[k][11:6];
         c = m_nz[k][5:0];
         if (r >= n || c >= n) begin
            m_err = 1'b1;
            continue;
         end
         a = dst[tr ? c : r] + src[tr ? r : c];
         if (a > (64'sd1 <<< 62)) a = 64'sd1 <<< 62;
         if (a < -(64'sd1 <<< 62)) a = -(64'sd1 <<< 62);
         dst[tr ? c : r] = a;
      end
      for (int i = 0; i < n; i++) begin
         if (dst[i] > (64'sd1 <<< 47) - 1) begin
            dst[i] = (64'sd1 <<< 47) - 1;
            m_err = 1'b1;
         end
         if (dst[i] < -(64'sd1 <<< 47)) begin
            dst[i] = -(64'sd1 <<< 47);
            m_err = 1'b1;
         end
      end
   endfunction

   // apply one accepted beat to the model, queue any result elements
   function automatic void predict_beat(input cmd_type c);
      int n;
      bit tr;
      logic signed [63:0] cur [DIM_MAX];
      logic signed [63:0] nxt [DIM_MAX];
      elem_type e;
      n = (m_dim == 0) ? 1 : (m_dim > DIM_MAX) ? DIM_MAX : int'(m_dim);
      case (c.kind)
         REQ_CLEAR: begin
            for (int i = 0; i < DIM_MAX; i++) m_vec[i] = 0;
            m_nnz = 0;
            m_err = 1'b0;
         end
         REQ_ADD: begin
            if (c.row >= n || c.col >= n || m_nnz >= NZ_MAX) m_err = 1'b1;
            else begin
               m_nz[m_nnz] = {c.row, c.col};
               m_nnz++;
            end
         end
         REQ_LOAD: begin
            if (c.vix >= n) m_err = 1'b1;
            else m_vec[c.vix] = 64'(signed'(c.value));
         end
         REQ_START: begin
            tr = m_mode;
            sparse_pass(m_vec, cur, n, tr);
            for (int i = 0; i < 2 * m_rounds; i++) begin
               tr = !tr;
               sparse_pass(cur, nxt, n, tr);
               cur = nxt;
            end
            for (int i = 0; i < n; i++) begin
               e.idx = 6'(i);
               e.value = cur[i][47:0];
               e.last = (i == n - 1);
               e.err = m_err;
               want_q.push_back(e);
            end
         end
         default: ;
      endcase
   endfunction

   // driver: holds push high while the queue has beats, random bursts of gaps
   int gap_left;
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_beat(cmd_q.pop_front());
            n_beats_in++;
         end
         if (push && full) begin
            // hold current beat
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 15);
            push <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            cmd_type c;
            c = cmd_q[0];
            push <= 1'b1;
            req_type <= c.kind;
            req_row_index <= c.row;
            req_col_index <= c.col;
            req_vector_index <= c.vix;
            req_vector_value <= c.value;
         end else push <= 1'b0;
      end
   end

   // monitor: random pop stalls, compares every accepted result beat
   int stall_left;
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            n_beats_out++;
            if (want_q.size() == 0) begin
               $display("%0t: unexpected result idx %0d value %h", $time,
                        rsp_result_index, rsp_result_value);
               errors++;
            end else begin
               elem_type w;
               w = want_q.pop_front();
               if (w.idx !== rsp_result_index) begin
                  $display("%0t: result_index exp %0d got %0d", $time, w.idx,
                           rsp_result_index);
                  errors++;
               end
               if (w.value !== rsp_result_value) begin
                  $display("%0t: result_value[%0d] exp %h got %h", $time, w.idx,
                           w.value, rsp_result_value);
                  errors++;
               end
               if (w.last !== rsp_last_flag) begin
                  $display("%0t: last_flag[%0d] exp %b got %b", $time, w.idx,
                           w.last, rsp_last_flag);
                  errors++;
               end
               if (w.err !== rsp_error_flag) begin
                  $display("%0t: error_flag[%0d] exp %b got %b", $time, w.idx,
                           w.err, rsp_error_flag);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            pop <= 1'b0;
         end else pop <= 1'b1;
      end
   end

   // watchdog: cycles with no beat accepted on the request or result channel
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) cycles_idle <= 0;
      else cycles_idle <= cycles_idle + 1;
      if (cycles_idle >= WDOG_LIM) begin
         $display("watchdog expired");
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic cmd_type mk(input req_kind_type k, input int r, input int c,
                                  input int v, input logic [31:0] val);
      cmd_type x;
      x.kind = k;
      x.row = 6'(r);
      x.col = 6'(c);
      x.vix = 6'(v);
      x.value = val;
      return x;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [6:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DIMENSION: m_dim = val;
         CSR_CHAIN_MODE: m_mode = val[0];
         CSR_POWER_COUNT: m_rounds = val[3:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int d, input int m, input int q);
      csr_write(CSR_DIMENSION, 7'(d));
      csr_write(CSR_CHAIN_MODE, 7'(m));
      csr_write(CSR_POWER_COUNT, 7'(q));
   endtask

   // wait until all beats went in and all results came out, then let the
   // engine settle (a trailing add/load/clear leaves no result to wait for)
   task automatic drain();
      while (cmd_q.size() != 0 || want_q.size() != 0 || push) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // random phase: well-formed matrix and vector, a few broken beats, start
   task automatic random_phase(input int n, input int nnz, input bit big);
      cmd_q.push_back(mk(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
      for (int i = 0; i < nnz; i++) begin
         if ($urandom_range(0, 19) == 0)
            cmd_q.push_back(mk(REQ_ADD, $urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom, $urandom));
         else
            cmd_q.push_back(mk(REQ_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                               $urandom, $urandom));
      end
      for (int i = 0; i < n; i++) begin
         logic [31:0] v;
         v = big ? $urandom : 32'($signed($urandom_range(0, 8191)) - 4096) <<< 12;
         cmd_q.push_back(mk(REQ_LOAD, $urandom, $urandom,
                            ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : i, v));
      end
      cmd_q.push_back(mk(REQ_START, $urandom, $urandom, $urandom, $urandom));
   endtask

   initial begin
      m_dim = DIM_RESET;
      m_mode = 1'b0;
      m_rounds = '0;
      m_nnz = 0;
      m_err = 1'b0;
      for (int i = 0; i < DIM_MAX; i++) m_vec[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: start on reset state at dimension 64, then extremes
      cmd_q.push_back(mk(REQ_START, 0, 0, 0, 0));
      drain();
      configure(4, 0, 1);
      cmd_q.push_back(mk(REQ_ADD, 0, 1, 0, 0));
      cmd_q.push_back(mk(REQ_ADD, 3, 3, 0, 0));
      cmd_q.push_back(mk(REQ_ADD, 1, 0, 0, 0));
      cmd_q.push_back(mk(REQ_ADD, 63, 0, 0, 0));          // bad row
      cmd_q.push_back(mk(REQ_ADD, 0, 63, 0, 0));          // bad column
      cmd_q.push_back(mk(REQ_LOAD, 0, 0, 0, 32'h7fffffff));
      cmd_q.push_back(mk(REQ_LOAD, 0, 0, 1, 32'h80000000));
      cmd_q.push_back(mk(REQ_LOAD, 0, 0, 3, 32'h00010000));
      cmd_q.push_back(mk(REQ_LOAD, 0, 0, 63, 32'hffffffff)); // bad vector index
      cmd_q.push_back(mk(REQ_START, 0, 0, 0, 0));
      cmd_q.push_back(mk(REQ_CLEAR, 0, 0, 0, 0));
      cmd_q.push_back(mk(REQ_ADD, 2, 2, 0, 0));
      cmd_q.push_back(mk(REQ_LOAD, 0, 0, 2, 32'h7fffffff));
      drain();
      // stale nonzero: shrink dimension below a stored entry; mode 1
      configure(2, 1, 0);
      cmd_q.push_back(mk(REQ_START, 0, 0, 0, 0));
      drain();
      // saturation: self loops amplify over 15 rounds; dimension 0 reads as 1
      configure(0, 0, 15);
      cmd_q.push_back(mk(REQ_CLEAR, 0, 0, 0, 0));
      for (int i = 0; i < 8; i++) cmd_q.push_back(mk(REQ_ADD, 0, 0, 0, 0));
      cmd_q.push_back(mk(REQ_LOAD, 0, 0, 0, 32'h7fffffff));
      cmd_q.push_back(mk(REQ_START, 0, 0, 0, 0));
      drain();
      // dimension above the maximum is clamped
      configure(127, 1, 0);
      cmd_q.push_back(mk(REQ_START, 0, 0, 0, 0));
      drain();

      // random phases, mostly small sizes, one at the maximum
      for (int p = 0; p < 12; p++) begin
         int n;
         n = (p == 5) ? DIM_MAX : $urandom_range(1, 12);
         if (p == 10) quiet = 1'b1;
         configure(n, $urandom_range(0, 1), (p == 5) ? $urandom_range(0, 2)
                                                     : $urandom_range(0, 5));
         random_phase(n, $urandom_range(0, 2 * n), p % 3 == 0);
         if (p != 5) random_phase(n, $urandom_range(1, n), 1'b0);
         drain();
      end

      $display("Covered %0d request beats (%0d result beats), all request kinds,",
               n_beats_in, n_beats_out);
      $display("both chain modes, dimensions 1..64, rounds 0..15, error cases.");
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
